[sv/qrr_pkg.sv]
package qrr_pkg;

    localparam int COEF_W    = 16;                  // width of a, b, c
    localparam int PROD_W    = 2 * COEF_W;          // a*c, b*b
    localparam int DISC_W    = 2 * COEF_W + 1;      // b*b - 4*a*c when not negative
    localparam int RAD_W     = DISC_W + 1;          // radicand padded to whole bit pairs
    localparam int SQ_STEPS  = RAD_W / 2;           // one result bit per stage
    localparam int SQ_REM_W  = SQ_STEPS + 1;        // remainder never exceeds 2*root
    localparam int DEN_W     = COEF_W + 1;          // |2a|
    localparam int NUM_W     = COEF_W + 1;          // |s -+ b| fits below 2^17
    localparam int NS_W      = NUM_W + 2;           // signed numerator before magnitude
    localparam int ROOT_FRAC = 16;                  // Q16.16 output
    localparam int DVD_W     = NUM_W + ROOT_FRAC;   // scaled numerator
    localparam int DV_STEPS  = DVD_W;               // one quotient bit per stage
    localparam int ROOT_W    = 32;
    localparam int S_DATA_W  = ((3 * COEF_W + 7) / 8) * 8;
    localparam int M_FIELD_W = 2 * ROOT_W + 2;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [DV_STEPS-1:0] ROOT_MAX_MAG = DV_STEPS'(64'h7FFF_FFFF);
    localparam logic [DV_STEPS-1:0] ROOT_MIN_MAG = DV_STEPS'(64'h8000_0000);

    // side data that rides along with the square root
    typedef struct packed {
        logic                     ok;     // a nonzero and discriminant not negative
        logic                     a_neg;
        logic [DEN_W-1:0]         den;    // |2a|
        logic signed [COEF_W-1:0] b;
    } qrr_side_t;

endpackage

[sv/qrr_disc.sv]
module qrr_disc import qrr_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_vld,
    input  logic signed [COEF_W-1:0] coef_a,
    input  logic signed [COEF_W-1:0] coef_b,
    input  logic signed [COEF_W-1:0] coef_c,
    output logic                     out_vld,
    output logic [DISC_W-1:0]        disc,
    output qrr_side_t                side
);

    logic                     v1_reg, v2_reg;
    logic signed [PROD_W-1:0] bb_reg, ac_reg;
    logic signed [COEF_W-1:0] a1_reg, b1_reg;
    logic [DISC_W-1:0]        disc_reg;
    qrr_side_t                side_reg;

    logic signed [PROD_W+2:0] d_full;
    logic [COEF_W-1:0]        a_mag;
    qrr_side_t                side_next;
    logic [DISC_W-1:0]        disc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
        end
    end

    // stage 1: the two products
    always_ff @(posedge aclk) begin
        if (adv) begin
            bb_reg <= coef_b * coef_b;
            ac_reg <= coef_a * coef_c;
            a1_reg <= coef_a;
            b1_reg <= coef_b;
        end
    end

    // stage 2: discriminant, validity, denominator
    always_comb begin
        d_full = {{3{bb_reg[PROD_W-1]}}, bb_reg}
               - ({{3{ac_reg[PROD_W-1]}}, ac_reg} <<< 2);
        a_mag  = a1_reg[COEF_W-1] ? COEF_W'(-a1_reg) : COEF_W'(a1_reg);
        side_next.ok    = !d_full[PROD_W+2] && (a1_reg != '0);
        side_next.a_neg = a1_reg[COEF_W-1];
        side_next.den   = {a_mag, 1'b0};
        side_next.b     = b1_reg;
        disc_next = side_next.ok ? d_full[DISC_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            disc_reg <= disc_next;
            side_reg <= side_next;
        end
    end

    assign out_vld = v2_reg;
    assign disc    = disc_reg;
    assign side    = side_reg;

endmodule

[sv/qrr_sqrt.sv]
module qrr_sqrt import qrr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_vld,
    input  logic [DISC_W-1:0]   disc,
    input  qrr_side_t           in_side,
    output logic                out_vld,
    output logic [SQ_STEPS-1:0] root,
    output qrr_side_t           out_side
);

    logic                vld_reg  [SQ_STEPS];
    logic [RAD_W-1:0]    rad_reg  [SQ_STEPS];
    logic [SQ_STEPS-1:0] root_reg [SQ_STEPS];
    logic [SQ_REM_W-1:0] rem_reg  [SQ_STEPS];
    qrr_side_t           side_reg [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
        logic                cur_vld;
        logic [RAD_W-1:0]    cur_rad;
        logic [SQ_STEPS-1:0] cur_root;
        logic [SQ_REM_W-1:0] cur_rem;
        qrr_side_t           cur_side;
        logic [SQ_REM_W+1:0] rem_sh, trial;
        logic                take;

        if (k == 0) begin : g_first
            assign cur_vld  = in_vld;
            assign cur_rad  = {1'b0, disc};
            assign cur_root = '0;
            assign cur_rem  = '0;
            assign cur_side = in_side;
        end else begin : g_next
            assign cur_vld  = vld_reg[k-1];
            assign cur_rad  = rad_reg[k-1];
            assign cur_root = root_reg[k-1];
            assign cur_rem  = rem_reg[k-1];
            assign cur_side = side_reg[k-1];
        end

        // bring down the next bit pair, try (4*root + 1)
        assign rem_sh = {cur_rem, cur_rad[RAD_W-1 -: 2]};
        assign trial  = {1'b0, cur_root, 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_reg[k]  <= {cur_rad[RAD_W-3:0], 2'b00};
                root_reg[k] <= {cur_root[SQ_STEPS-2:0], take};
                rem_reg[k]  <= take ? SQ_REM_W'(rem_sh - trial) : rem_sh[SQ_REM_W-1:0];
                side_reg[k] <= cur_side;
            end
        end
    end

    assign out_vld  = vld_reg[SQ_STEPS-1];
    assign root     = root_reg[SQ_STEPS-1];
    assign out_side = side_reg[SQ_STEPS-1];

endmodule

[sv/qrr_div.sv]
module qrr_div import qrr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_vld,
    input  logic [SQ_STEPS-1:0] root,
    input  qrr_side_t           in_side,
    output logic                out_vld,
    output logic [M_FIELD_W-1:0] out_word
);

    // numerator stage
    logic                 nv_reg;
    logic                 nok_reg;
    logic [DEN_W-1:0]     nden_reg;
    logic [NUM_W-1:0]     nmag_reg [2];
    logic                 nneg_reg [2];

    logic signed [NS_W-1:0] s_ext, b_ext, np, nm;

    always_comb begin
        s_ext = $signed({{(NS_W-SQ_STEPS){1'b0}}, root});
        b_ext = NS_W'(in_side.b);
        np    = s_ext - b_ext;
        nm    = -b_ext - s_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg <= 1'b0;
        end else if (adv) begin
            nv_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nok_reg     <= in_side.ok;
            nden_reg    <= in_side.den;
            nmag_reg[0] <= np[NS_W-1] ? NUM_W'(-np) : NUM_W'(np);
            nmag_reg[1] <= nm[NS_W-1] ? NUM_W'(-nm) : NUM_W'(nm);
            nneg_reg[0] <= np[NS_W-1] ^ in_side.a_neg;
            nneg_reg[1] <= nm[NS_W-1] ^ in_side.a_neg;
        end
    end

    // restoring division, both lanes share the denominator
    logic                vld_reg [DV_STEPS];
    logic                ok_reg  [DV_STEPS];
    logic [DEN_W-1:0]    den_reg [DV_STEPS];
    logic [DVD_W-1:0]    dvd_reg [2][DV_STEPS];
    logic [DEN_W-1:0]    rem_reg [2][DV_STEPS];
    logic [DV_STEPS-1:0] quo_reg [2][DV_STEPS];
    logic                neg_reg [2][DV_STEPS];

    for (genvar k = 0; k < DV_STEPS; k++) begin : g_stage
        logic             cur_vld, cur_ok;
        logic [DEN_W-1:0] cur_den;

        if (k == 0) begin : g_first
            assign cur_vld = nv_reg;
            assign cur_ok  = nok_reg;
            assign cur_den = nden_reg;
        end else begin : g_next
            assign cur_vld = vld_reg[k-1];
            assign cur_ok  = ok_reg[k-1];
            assign cur_den = den_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                ok_reg[k]  <= cur_ok;
                den_reg[k] <= cur_den;
            end
        end

        for (genvar ln = 0; ln < 2; ln++) begin : g_lane
            logic [DVD_W-1:0]    cur_dvd;
            logic [DEN_W-1:0]    cur_rem;
            logic [DV_STEPS-1:0] cur_quo;
            logic                cur_neg;
            logic [DEN_W:0]      rem_sh;
            logic                take;

            if (k == 0) begin : g_first
                assign cur_dvd = {nmag_reg[ln], {ROOT_FRAC{1'b0}}};
                assign cur_rem = '0;
                assign cur_quo = '0;
                assign cur_neg = nneg_reg[ln];
            end else begin : g_next
                assign cur_dvd = dvd_reg[ln][k-1];
                assign cur_rem = rem_reg[ln][k-1];
                assign cur_quo = quo_reg[ln][k-1];
                assign cur_neg = neg_reg[ln][k-1];
            end

            assign rem_sh = {cur_rem, cur_dvd[DVD_W-1]};
            assign take   = rem_sh >= {1'b0, cur_den};

            always_ff @(posedge aclk) begin
                if (adv) begin
                    dvd_reg[ln][k] <= {cur_dvd[DVD_W-2:0], 1'b0};
                    rem_reg[ln][k] <= take ? DEN_W'(rem_sh - {1'b0, cur_den})
                                           : rem_sh[DEN_W-1:0];
                    quo_reg[ln][k] <= {cur_quo[DV_STEPS-2:0], take};
                    neg_reg[ln][k] <= cur_neg;
                end
            end
        end
    end

    // sign, clamp to Q16.16, mask invalid results
    logic [ROOT_W-1:0] res [2];
    logic              sat [2];

    always_comb begin
        for (int ln = 0; ln < 2; ln++) begin
            if (neg_reg[ln][DV_STEPS-1]) begin
                sat[ln] = quo_reg[ln][DV_STEPS-1] > ROOT_MIN_MAG;
                res[ln] = sat[ln] ? ROOT_MIN_MAG[ROOT_W-1:0]
                                  : ROOT_W'(-quo_reg[ln][DV_STEPS-1]);
            end else begin
                sat[ln] = quo_reg[ln][DV_STEPS-1] > ROOT_MAX_MAG;
                res[ln] = sat[ln] ? ROOT_MAX_MAG[ROOT_W-1:0]
                                  : quo_reg[ln][DV_STEPS-1][ROOT_W-1:0];
            end
        end
    end

    logic                 ov_reg;
    logic [M_FIELD_W-1:0] word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (adv) begin
            ov_reg <= vld_reg[DV_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (ok_reg[DV_STEPS-1]) begin
                word_reg <= {sat[0] | sat[1], res[1], res[0], 1'b1};
            end else begin
                word_reg <= '0;
            end
        end
    end

    assign out_vld  = ov_reg;
    assign out_word = word_reg;

endmodule

[sv/quadratic_real_roots.sv]
// Stages from an accepted input word to its result word: product/discriminant,
// square root, numerator, divide, output register.
// Throughput: one equation per cycle; the whole pipeline halts as one while a
// result word waits and m_tready is low.
// Reset: synchronous, active low on aresetn; clears every stage valid bit.
module quadratic_real_roots import qrr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // coef_a[15:0], coef_b[31:16], coef_c[47:32]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // has_two_roots[0], root_plus[32:1],
                                           // root_minus[64:33], saturated[65], zero pad
);

    // Advance every stage when the output register is empty or being drained.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic                disc_vld;
    logic [DISC_W-1:0]   disc;
    qrr_side_t           disc_side;

    // Products, discriminant, validity and |2a|.
    qrr_disc u_disc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (s_tvalid),
        .coef_a  (s_tdata[COEF_W-1:0]),
        .coef_b  (s_tdata[2*COEF_W-1:COEF_W]),
        .coef_c  (s_tdata[3*COEF_W-1:2*COEF_W]),
        .out_vld (disc_vld),
        .disc    (disc),
        .side    (disc_side)
    );

    logic                sq_vld;
    logic [SQ_STEPS-1:0] sq_root;
    qrr_side_t           sq_side;

    // Floor square root, one result bit per stage.
    qrr_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (disc_vld),
        .disc     (disc),
        .in_side  (disc_side),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .out_side (sq_side)
    );

    logic                 out_vld;
    logic [M_FIELD_W-1:0] out_word;

    // Both numerators, two dividers in lockstep, sign, clamp and output register.
    qrr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (sq_vld),
        .root     (sq_root),
        .in_side  (sq_side),
        .out_vld  (out_vld),
        .out_word (out_word)
    );

    assign m_tvalid = out_vld;
    assign m_tdata  = {{(M_DATA_W-M_FIELD_W){1'b0}}, out_word};

    // An equation without two real roots carries all zero fields.
    a_invalid_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[M_FIELD_W-1:1] == '0)
        else $error("invalid result with nonzero fields");

    // Input is taken exactly when the output side can move.
    a_ready_link : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output stage");

    // A held result word must not change under stall.
    a_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule
